FILE: rtl/utf8v_pkg.sv
package utf8v_pkg;

  localparam int unsigned MAX_BYTES_DEF = 4096;

  // lead byte ranges (RFC 3629)
  localparam logic [7:0] ASCII_MAX  = 8'h7F;
  localparam logic [7:0] LEAD2_LO   = 8'hC2;
  localparam logic [7:0] LEAD2_HI   = 8'hDF;
  localparam logic [7:0] LEAD3_LO   = 8'hE0;
  localparam logic [7:0] LEAD3_HI   = 8'hEF;
  localparam logic [7:0] LEAD4_LO   = 8'hF0;
  localparam logic [7:0] LEAD4_HI   = 8'hF4;
  localparam logic [7:0] LEAD_E0    = 8'hE0;
  localparam logic [7:0] LEAD_ED    = 8'hED;
  localparam logic [7:0] LEAD_F0    = 8'hF0;
  localparam logic [7:0] LEAD_F4    = 8'hF4;
  localparam logic [7:0] NUL_BYTE   = 8'h00;

  // continuation byte bounds
  localparam logic [7:0] CONT_LO    = 8'h80;
  localparam logic [7:0] CONT_HI    = 8'hBF;
  localparam logic [7:0] CONT_LO_E0 = 8'hA0;
  localparam logic [7:0] CONT_HI_ED = 8'h9F;
  localparam logic [7:0] CONT_LO_F0 = 8'h90;
  localparam logic [7:0] CONT_HI_F4 = 8'h8F;

  typedef enum logic [2:0] {
    RULE_ANY = 3'd0,
    RULE_E0  = 3'd1,
    RULE_ED  = 3'd2,
    RULE_F0  = 3'd3,
    RULE_F4  = 3'd4
  } rule_t;

  typedef struct packed {
    logic [1:0] due;
    rule_t      rule;
    logic       err;
  } seq_state_t;

  localparam seq_state_t ST_RESET = '{due: 2'd0, rule: RULE_ANY, err: 1'b0};

  function automatic logic cont_ok(input logic [7:0] b, input rule_t rule);
    logic [7:0] lo;
    logic [7:0] hi;
    lo = CONT_LO;
    hi = CONT_HI;
    case (rule)
      RULE_E0: lo = CONT_LO_E0;
      RULE_ED: hi = CONT_HI_ED;
      RULE_F0: lo = CONT_LO_F0;
      RULE_F4: hi = CONT_HI_F4;
      default: ;
    endcase
    return (b >= lo) && (b <= hi);
  endfunction

endpackage

FILE: rtl/utf8v_step.sv
module utf8v_step import utf8v_pkg::*; #(
  parameter int unsigned MAX_BYTES = MAX_BYTES_DEF,
  parameter int unsigned CNT_W     = $clog2(MAX_BYTES + 2)
) (
  input  logic [7:0]       byte_i,
  input  seq_state_t       st_i,
  input  logic [CNT_W-1:0] cnt_i,
  output seq_state_t       st_o,
  output logic [CNT_W-1:0] cnt_o,
  output logic             verdict_o
);

  logic over;

  // count saturates one past the limit; that is all the verdict needs
  always_comb begin
    if (cnt_i > CNT_W'(MAX_BYTES)) begin
      cnt_o = cnt_i;
    end else begin
      cnt_o = cnt_i + CNT_W'(1);
    end
  end

  assign over = (cnt_o > CNT_W'(MAX_BYTES));

  always_comb begin
    st_o     = st_i;
    st_o.err = st_i.err | over;
    if (st_i.due != 2'd0) begin
      if (!cont_ok(byte_i, st_i.rule)) begin
        st_o.err = 1'b1;
      end
      st_o.due  = st_i.due - 2'd1;
      st_o.rule = RULE_ANY;
    end else if (byte_i <= ASCII_MAX) begin
      if (byte_i == NUL_BYTE) begin
        st_o.err = 1'b1;
      end
    end else if (byte_i >= LEAD2_LO && byte_i <= LEAD2_HI) begin
      st_o.due  = 2'd1;
      st_o.rule = RULE_ANY;
    end else if (byte_i >= LEAD3_LO && byte_i <= LEAD3_HI) begin
      st_o.due  = 2'd2;
      st_o.rule = (byte_i == LEAD_E0) ? RULE_E0 :
                  (byte_i == LEAD_ED) ? RULE_ED : RULE_ANY;
    end else if (byte_i >= LEAD4_LO && byte_i <= LEAD4_HI) begin
      st_o.due  = 2'd3;
      st_o.rule = (byte_i == LEAD_F0) ? RULE_F0 :
                  (byte_i == LEAD_F4) ? RULE_F4 : RULE_ANY;
    end else begin
      // stray continuation or a lead byte that can never start a sequence
      st_o.err = 1'b1;
    end
  end

  assign verdict_o = !st_o.err && (st_o.due == 2'd0);

endmodule

FILE: rtl/utf8_string_validator.sv
// UTF-8 string validator. Bytes of a string arrive one per transfer, the last one flagged
// with in_last_byte; after the last byte one transfer on the out_ channel carries
// out_string_valid, which is 1 only if the string is well-formed UTF-8 (no overlong forms,
// surrogates, code points above U+10FFFF, stray or missing continuation bytes), holds no NUL
// byte and is at most MAX_BYTES long. A byte is taken every cycle while the result side keeps
// up; the last byte is held in the input register, then its verdict in the result register.
// The limit is the combinational update of the sequence state from one byte to the next. After
// each verdict the block starts fresh on the next string, which may follow immediately.
module utf8_string_validator import utf8v_pkg::*; #(
  parameter int unsigned MAX_BYTES = MAX_BYTES_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte_value,
  input  logic       in_last_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_string_valid
);

  localparam int unsigned CNT_W = $clog2(MAX_BYTES + 2);

  logic             in_valid_r;
  logic [7:0]       byte_r;
  logic             last_r;
  seq_state_t       st_r;
  seq_state_t       st_nxt;
  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] cnt_nxt;
  logic             verdict;
  logic             out_valid_r;
  logic             out_sv_r;
  logic             adv;

  utf8v_step #(
    .MAX_BYTES (MAX_BYTES),
    .CNT_W     (CNT_W)
  ) u_step (
    .byte_i    (byte_r),
    .st_i      (st_r),
    .cnt_i     (cnt_r),
    .st_o      (st_nxt),
    .cnt_o     (cnt_nxt),
    .verdict_o (verdict)
  );

  // only a last byte needs room in the result register
  assign adv      = in_valid_r && (!last_r || !out_valid_r || out_ready);
  assign in_ready = !in_valid_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      st_r        <= ST_RESET;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ready) begin
        in_valid_r <= in_valid;
      end
      if (adv) begin
        if (last_r) begin
          st_r  <= ST_RESET;
          cnt_r <= '0;
        end else begin
          st_r  <= st_nxt;
          cnt_r <= cnt_nxt;
        end
      end
      if (adv && last_r) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      byte_r <= in_byte_value;
      last_r <= in_last_byte;
    end
    if (adv && last_r) begin
      out_sv_r <= verdict;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_string_valid = out_sv_r;

  a_fresh_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && last_r) |=> (cnt_r == '0 && st_r.due == 2'd0 && !st_r.err))
    else $error("sequence state not cleared after end of string");

  a_result_from_last: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(adv && last_r))
    else $error("result raised without a last byte");

  a_over_limit_err: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r > CNT_W'(MAX_BYTES)) |-> st_r.err)
    else $error("length over limit without error");

  a_rule_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r.due == 2'd0) |-> (st_r.rule == RULE_ANY))
    else $error("continuation rule left set with no sequence open");

endmodule
